// File: sv/pa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pa_pkg;

   // default geometry
   localparam int PA_MAX_PARTITIONS = 32;
   localparam int PA_ADDR_BITS      = 20;

   // request function codes
   typedef enum logic [1:0] {
      FN_INIT   = 2'd0,
      FN_APPEND = 2'd1,
      FN_ALLOC  = 2'd2,
      FN_FREE   = 2'd3
   } pa_func_type;

   // response status codes
   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_NOFIT    = 2'd1,
      ST_NOTFOUND = 2'd2,
      ST_FULL     = 2'd3
   } pa_status_type;

   // csr register indexes
   typedef enum logic [1:0] {
      CSR_DYNAMIC = 2'd0,
      CSR_POLICY  = 2'd1,
      CSR_MEMSIZE = 2'd2
   } pa_csr_type;

   // fit policies
   localparam logic [1:0] POL_BEST  = 2'd1;
   localparam logic [1:0] POL_WORST = 2'd2;

   // datapath operations
   typedef enum logic [3:0] {
      OP_NONE, OP_LOAD, OP_INIT, OP_APPEND, OP_RESTART, OP_SET_NOFIT, OP_SET_FULL,
      OP_SET_NOTFOUND, OP_SHIFT_SETUP, OP_SPLIT_HI, OP_COMMIT, OP_FREE_MARK,
      OP_MERGE_END, OP_FINISH
   } pa_op_type;

   // purpose of a table read
   typedef enum logic [2:0] {
      RD_NONE, RD_ALLOC, RD_FREE, RD_SHIFT, RD_MERGE
   } pa_rd_type;

   typedef struct packed {
      pa_op_type op;
      pa_rd_type rd;
   } pa_cmd_type;

   typedef struct packed {
      pa_func_type func;
      logic        dyn;
      logic        found;
      logic        rest_nz;
      logic        full;
      logic        ptr_lt_cnt;
      logic        ptr_gt_pick1;
      logic        rd_busy;
      logic        out_busy;
   } pa_stat_type;

endpackage

`default_nettype wire

// File: sv/pa_chan_if.sv
`timescale 1ns / 1ps
`default_nettype none

// request channel
interface pa_req_if import pa_pkg::*; #(
   parameter int ADDR_BITS = PA_ADDR_BITS
);
   logic                 valid;
   logic                 ready;
   logic [1:0]           func;
   logic [ADDR_BITS:0]   req_size;
   logic [ADDR_BITS-1:0] req_base;

   modport source (output valid, func, req_size, req_base, input ready);
   modport sink   (input valid, func, req_size, req_base, output ready);
endinterface

// response channel
interface pa_rsp_if import pa_pkg::*; #(
   parameter int ADDR_BITS      = PA_ADDR_BITS,
   parameter int MAX_PARTITIONS = PA_MAX_PARTITIONS
);
   logic                                 valid;
   logic                                 ready;
   logic [1:0]                           status;
   logic [ADDR_BITS-1:0]                 granted_base;
   logic [ADDR_BITS:0]                   granted_size;
   logic [$clog2(MAX_PARTITIONS+1)-1:0]  entry_count;

   modport source (output valid, status, granted_base, granted_size, entry_count,
                   input ready);
   modport sink   (input valid, status, granted_base, granted_size, entry_count,
                   output ready);
endinterface

`default_nettype wire

// File: sv/pa_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module pa_datapath import pa_pkg::*; #(
   parameter int MAX_PARTITIONS = PA_MAX_PARTITIONS,
   parameter int ADDR_BITS      = PA_ADDR_BITS,
   localparam int SIZE_W        = ADDR_BITS + 1,
   localparam int IDX_W         = $clog2(MAX_PARTITIONS),
   localparam int CNT_W         = $clog2(MAX_PARTITIONS + 1)
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire pa_cmd_type           cmd,
   output pa_stat_type               stat,
   input  wire logic                 csr_wr_en,
   input  wire logic [1:0]           csr_index,
   input  wire logic [SIZE_W-1:0]    csr_data,
   input  wire logic [1:0]           req_func,
   input  wire logic [SIZE_W-1:0]    req_size,
   input  wire logic [ADDR_BITS-1:0] req_base,
   input  wire logic                 rsp_ready,
   output logic                      rsp_valid,
   output logic [1:0]                rsp_status,
   output logic [ADDR_BITS-1:0]      rsp_base,
   output logic [SIZE_W-1:0]         rsp_size,
   output logic [CNT_W-1:0]          rsp_count
);

   localparam logic [SIZE_W-1:0] MEM_FULL = {1'b1, {ADDR_BITS{1'b0}}};
   localparam logic [SIZE_W-1:0] ADDR_MASK = {1'b0, {ADDR_BITS{1'b1}}};

   // partition table storage
   logic [SIZE_W-1:0] mem_base [MAX_PARTITIONS];
   logic [SIZE_W-1:0] mem_size [MAX_PARTITIONS];

   // config registers
   logic dyn_ff, dyn_in;
   logic [1:0] pol_ff, pol_in;
   logic [SIZE_W-1:0] msize_ff, msize_in;

   // latched request
   pa_func_type func_ff, func_in;
   logic [SIZE_W-1:0] rsize_ff, rsize_in;
   logic [ADDR_BITS-1:0] rbase_ff, rbase_in;

   // table control
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [SIZE_W-1:0] nfb_ff, nfb_in;
   logic [MAX_PARTITIONS-1:0] used_ff, used_in;
   logic e0dflt_ff, e0dflt_in;

   // read pipeline
   logic [CNT_W-1:0] ptr_ff, ptr_in, ptr_m1;
   pa_rd_type rd_tag_ff, rd_tag_in;
   logic [IDX_W-1:0] rd_idx_ff, ra;
   logic rd_go, rd_used_ff, rd_dflt_ff;
   logic [SIZE_W-1:0] mb_q, ms_q;
   logic [SIZE_W-1:0] e_base, e_size;

   // search and merge state
   logic found_ff, found_in;
   logic [IDX_W-1:0] pick_ff, pick_in, pick_p1;
   logic [SIZE_W-1:0] pick_base_ff, pick_base_in, pick_size_ff, pick_size_in;
   logic [CNT_W-1:0] wptr_ff, wptr_in;
   logic hold_v_ff, hold_v_in, hold_u_ff, hold_u_in;
   logic [SIZE_W-1:0] hold_base_ff, hold_base_in, hold_size_ff, hold_size_in;

   // per-item result
   pa_status_type st_ff, st_in;
   logic [ADDR_BITS-1:0] gbase_ff, gbase_in;
   logic [SIZE_W-1:0] gsize_ff, gsize_in;

   // output register
   logic out_v_ff, out_v_in;
   logic [1:0] out_st_ff, out_st_in;
   logic [ADDR_BITS-1:0] out_base_ff, out_base_in;
   logic [SIZE_W-1:0] out_size_ff, out_size_in;
   logic [CNT_W-1:0] out_cnt_ff, out_cnt_in;

   // write port
   logic wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic [SIZE_W-1:0] wr_base, wr_size;

   // arithmetic helpers
   logic [SIZE_W:0] app_end, merge_sum;
   logic [SIZE_W-1:0] init_m, rest, split_base;
   logic cand, take;

   assign ptr_m1  = ptr_ff - CNT_W'(1);
   assign pick_p1 = pick_ff + IDX_W'(1);
   assign e_base  = rd_dflt_ff ? '0 : mb_q;
   assign e_size  = rd_dflt_ff ? MEM_FULL : ms_q;
   assign app_end = {1'b0, nfb_ff} + {1'b0, rsize_ff};
   assign merge_sum = {1'b0, hold_size_ff} + {1'b0, e_size};
   assign init_m  = (msize_ff > MEM_FULL) ? MEM_FULL : msize_ff;
   assign rest    = pick_size_ff - rsize_ff;
   assign split_base = (pick_base_ff + rsize_ff) & ADDR_MASK;

   // fit test on a returned entry
   always_comb begin
      cand = !rd_used_ff && (e_size >= rsize_ff);
      take = 1'b0;
      if (cand) begin
         if (!found_ff) take = 1'b1;
         else if (pol_ff == POL_BEST && e_size < pick_size_ff) take = 1'b1;
         else if (pol_ff == POL_WORST && e_size > pick_size_ff) take = 1'b1;
      end
   end

   // next-state logic
   always_comb begin
      dyn_in = dyn_ff; pol_in = pol_ff; msize_in = msize_ff;
      func_in = func_ff; rsize_in = rsize_ff; rbase_in = rbase_ff;
      cnt_in = cnt_ff; nfb_in = nfb_ff; used_in = used_ff;
      ptr_in = ptr_ff; rd_tag_in = RD_NONE; rd_go = 1'b0;
      found_in = found_ff; pick_in = pick_ff;
      pick_base_in = pick_base_ff; pick_size_in = pick_size_ff;
      wptr_in = wptr_ff; hold_v_in = hold_v_ff; hold_u_in = hold_u_ff;
      hold_base_in = hold_base_ff; hold_size_in = hold_size_ff;
      st_in = st_ff; gbase_in = gbase_ff; gsize_in = gsize_ff;
      out_v_in = out_v_ff && !rsp_ready;
      out_st_in = out_st_ff; out_base_in = out_base_ff;
      out_size_in = out_size_ff; out_cnt_in = out_cnt_ff;
      wr_en = 1'b0; wr_addr = '0; wr_base = '0; wr_size = '0;
      ra = ptr_ff[IDX_W-1:0];

      // config writes
      if (csr_wr_en) begin
         case (csr_index)
            CSR_DYNAMIC: dyn_in = csr_data[0];
            CSR_POLICY:  pol_in = csr_data[1:0];
            CSR_MEMSIZE: msize_in = csr_data;
            default: ;
         endcase
      end

      // issue a table read
      if (cmd.rd != RD_NONE) begin
         rd_go = 1'b1;
         rd_tag_in = cmd.rd;
         if (cmd.rd == RD_SHIFT) begin
            ra = ptr_m1[IDX_W-1:0];
            ptr_in = ptr_m1;
         end else begin
            ptr_in = ptr_ff + CNT_W'(1);
         end
      end

      // consume a returned entry
      case (rd_tag_ff)
         RD_ALLOC: begin
            if (take) begin
               found_in = 1'b1; pick_in = rd_idx_ff;
               pick_base_in = e_base; pick_size_in = e_size;
            end
         end
         RD_FREE: begin
            if (!found_ff && e_base == {1'b0, rbase_ff} && e_size == rsize_ff) begin
               found_in = 1'b1; pick_in = rd_idx_ff;
            end
         end
         RD_SHIFT: begin
            wr_en = 1'b1; wr_addr = rd_idx_ff + IDX_W'(1);
            wr_base = e_base; wr_size = e_size;
         end
         RD_MERGE: begin
            if (hold_v_ff && !hold_u_ff && !rd_used_ff) begin
               hold_size_in = (merge_sum > {1'b0, MEM_FULL}) ? MEM_FULL
                                                             : merge_sum[SIZE_W-1:0];
            end else begin
               if (hold_v_ff) begin
                  wr_en = 1'b1; wr_addr = wptr_ff[IDX_W-1:0];
                  wr_base = hold_base_ff; wr_size = hold_size_ff;
                  used_in[wptr_ff[IDX_W-1:0]] = hold_u_ff;
                  wptr_in = wptr_ff + CNT_W'(1);
               end
               hold_v_in = 1'b1; hold_u_in = rd_used_ff;
               hold_base_in = e_base; hold_size_in = e_size;
            end
         end
         default: ;
      endcase

      // controller operations
      case (cmd.op)
         OP_LOAD: begin
            func_in = pa_func_type'(req_func); rsize_in = req_size; rbase_in = req_base;
            st_in = ST_OK; gbase_in = '0; gsize_in = '0;
         end
         OP_INIT: begin
            used_in = '0; nfb_in = '0; cnt_in = '0;
            if (dyn_ff && init_m != '0) begin
               wr_en = 1'b1; wr_addr = '0; wr_base = '0; wr_size = init_m;
               cnt_in = CNT_W'(1);
            end
         end
         OP_APPEND: begin
            if (dyn_ff || app_end > {1'b0, MEM_FULL}) begin
               st_in = ST_NOFIT;
            end else if (stat.full) begin
               st_in = ST_FULL;
            end else begin
               wr_en = 1'b1; wr_addr = cnt_ff[IDX_W-1:0];
               wr_base = nfb_ff; wr_size = rsize_ff;
               used_in[cnt_ff[IDX_W-1:0]] = 1'b0;
               cnt_in = cnt_ff + CNT_W'(1);
               gbase_in = nfb_ff[ADDR_BITS-1:0]; gsize_in = rsize_ff;
               nfb_in = app_end[SIZE_W-1:0];
            end
         end
         OP_RESTART: begin
            ptr_in = '0; found_in = 1'b0; pick_in = '0;
            pick_base_in = '0; pick_size_in = '0;
         end
         OP_SET_NOFIT:    st_in = ST_NOFIT;
         OP_SET_FULL:     st_in = ST_FULL;
         OP_SET_NOTFOUND: st_in = ST_NOTFOUND;
         OP_SHIFT_SETUP:  ptr_in = cnt_ff;
         OP_SPLIT_HI: begin
            wr_en = 1'b1; wr_addr = pick_p1; wr_base = split_base; wr_size = rest;
            for (int k = 0; k < MAX_PARTITIONS; k++) begin
               if (k > int'(pick_p1)) used_in[k] = used_ff[k-1];
               else if (k == int'(pick_p1)) used_in[k] = 1'b0;
            end
            cnt_in = cnt_ff + CNT_W'(1);
         end
         OP_COMMIT: begin
            wr_en = 1'b1; wr_addr = pick_ff; wr_base = pick_base_ff;
            wr_size = dyn_ff ? rsize_ff : pick_size_ff;
            used_in[pick_ff] = 1'b1;
            gbase_in = pick_base_ff[ADDR_BITS-1:0];
            gsize_in = dyn_ff ? rsize_ff : pick_size_ff;
         end
         OP_FREE_MARK: begin
            used_in[pick_ff] = 1'b0;
            ptr_in = '0; wptr_in = '0; hold_v_in = 1'b0;
         end
         OP_MERGE_END: begin
            if (hold_v_ff) begin
               wr_en = 1'b1; wr_addr = wptr_ff[IDX_W-1:0];
               wr_base = hold_base_ff; wr_size = hold_size_ff;
               used_in[wptr_ff[IDX_W-1:0]] = hold_u_ff;
               cnt_in = wptr_ff + CNT_W'(1);
            end else begin
               cnt_in = wptr_ff;
            end
         end
         OP_FINISH: begin
            out_v_in = 1'b1; out_st_in = st_ff; out_base_in = gbase_ff;
            out_size_in = gsize_ff; out_cnt_in = cnt_ff;
         end
         default: ;
      endcase
   end

   // table memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_base[wr_addr] <= wr_base;
         mem_size[wr_addr] <= wr_size;
      end
      if (rd_go) begin
         mb_q <= mem_base[ra];
         ms_q <= mem_size[ra];
      end
   end

   assign e0dflt_in = e0dflt_ff && !(wr_en && wr_addr == '0);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         dyn_ff <= 1'b1; pol_ff <= '0; msize_ff <= MEM_FULL;
         cnt_ff <= CNT_W'(1); nfb_ff <= '0; used_ff <= '0; e0dflt_ff <= 1'b1;
         rd_tag_ff <= RD_NONE; out_v_ff <= 1'b0; found_ff <= 1'b0;
         hold_v_ff <= 1'b0; ptr_ff <= '0; wptr_ff <= '0; st_ff <= ST_OK;
      end else begin
         dyn_ff <= dyn_in; pol_ff <= pol_in; msize_ff <= msize_in;
         cnt_ff <= cnt_in; nfb_ff <= nfb_in; used_ff <= used_in; e0dflt_ff <= e0dflt_in;
         rd_tag_ff <= rd_tag_in; out_v_ff <= out_v_in; found_ff <= found_in;
         hold_v_ff <= hold_v_in; ptr_ff <= ptr_in; wptr_ff <= wptr_in; st_ff <= st_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      func_ff <= func_in; rsize_ff <= rsize_in; rbase_ff <= rbase_in;
      pick_ff <= pick_in; pick_base_ff <= pick_base_in; pick_size_ff <= pick_size_in;
      hold_u_ff <= hold_u_in; hold_base_ff <= hold_base_in; hold_size_ff <= hold_size_in;
      gbase_ff <= gbase_in; gsize_ff <= gsize_in;
      out_st_ff <= out_st_in; out_base_ff <= out_base_in;
      out_size_ff <= out_size_in; out_cnt_ff <= out_cnt_in;
      if (rd_go) begin
         rd_idx_ff <= ra;
         rd_used_ff <= used_ff[ra];
         rd_dflt_ff <= (ra == '0) && e0dflt_ff;
      end
   end

   // status to the controller
   always_comb begin
      stat.func         = func_ff;
      stat.dyn          = dyn_ff;
      stat.found        = found_ff;
      stat.rest_nz      = (pick_size_ff != rsize_ff);
      stat.full         = (cnt_ff >= CNT_W'(MAX_PARTITIONS));
      stat.ptr_lt_cnt   = (ptr_ff < cnt_ff);
      stat.ptr_gt_pick1 = (ptr_ff > (CNT_W'(pick_ff) + CNT_W'(1)));
      stat.rd_busy      = (rd_tag_ff != RD_NONE);
      stat.out_busy     = out_v_ff && !rsp_ready;
   end

   assign rsp_valid  = out_v_ff;
   assign rsp_status = out_st_ff;
   assign rsp_base   = out_base_ff;
   assign rsp_size   = out_size_ff;
   assign rsp_count  = out_cnt_ff;

endmodule

`default_nettype wire

// File: sv/pa_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module pa_ctrl import pa_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire pa_stat_type stat,
   output pa_cmd_type       cmd
);

   typedef enum logic [10:0] {
      S_IDLE      = 11'b00000000001,
      S_DECODE    = 11'b00000000010,
      S_SCAN      = 11'b00000000100,
      S_ALLOC_DEC = 11'b00000001000,
      S_SHIFT     = 11'b00000010000,
      S_SPLIT_HI  = 11'b00000100000,
      S_COMMIT    = 11'b00001000000,
      S_FREE_DEC  = 11'b00010000000,
      S_MERGE     = 11'b00100000000,
      S_MERGE_END = 11'b01000000000,
      S_FINISH    = 11'b10000000000
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE);

   // sequencing
   always_comb begin
      state_in = state_ff;
      cmd.op = OP_NONE;
      cmd.rd = RD_NONE;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op = OP_LOAD;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            case (stat.func)
               FN_INIT: begin cmd.op = OP_INIT; state_in = S_FINISH; end
               FN_APPEND: begin cmd.op = OP_APPEND; state_in = S_FINISH; end
               default: begin cmd.op = OP_RESTART; state_in = S_SCAN; end
            endcase
         end
         // one entry read per cycle, its result consumed in the cycle after the read
         S_SCAN: begin
            if (stat.ptr_lt_cnt) begin
               cmd.rd = (stat.func == FN_ALLOC) ? RD_ALLOC : RD_FREE;
            end else if (!stat.rd_busy) begin
               state_in = (stat.func == FN_ALLOC) ? S_ALLOC_DEC : S_FREE_DEC;
            end
         end
         S_ALLOC_DEC: begin
            if (!stat.found) begin
               cmd.op = OP_SET_NOFIT; state_in = S_FINISH;
            end else if (stat.dyn && stat.rest_nz) begin
               if (stat.full) begin
                  cmd.op = OP_SET_FULL; state_in = S_FINISH;
               end else begin
                  cmd.op = OP_SHIFT_SETUP; state_in = S_SHIFT;
               end
            end else begin
               cmd.op = OP_COMMIT; state_in = S_FINISH;
            end
         end
         // move entries above the pick up by one
         S_SHIFT: begin
            if (stat.ptr_gt_pick1) cmd.rd = RD_SHIFT;
            else if (!stat.rd_busy) state_in = S_SPLIT_HI;
         end
         S_SPLIT_HI: begin cmd.op = OP_SPLIT_HI; state_in = S_COMMIT; end
         S_COMMIT: begin cmd.op = OP_COMMIT; state_in = S_FINISH; end
         S_FREE_DEC: begin
            if (!stat.found) begin
               cmd.op = OP_SET_NOTFOUND; state_in = S_FINISH;
            end else begin
               cmd.op = OP_FREE_MARK;
               state_in = stat.dyn ? S_MERGE : S_FINISH;
            end
         end
         // compact the table, folding runs of free entries
         S_MERGE: begin
            if (stat.ptr_lt_cnt) cmd.rd = RD_MERGE;
            else if (!stat.rd_busy) state_in = S_MERGE_END;
         end
         S_MERGE_END: begin cmd.op = OP_MERGE_END; state_in = S_FINISH; end
         S_FINISH: begin
            if (!stat.out_busy) begin
               cmd.op = OP_FINISH; state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

endmodule

`default_nettype wire

// File: sv/partition_allocator.sv
`timescale 1ns / 1ps
`default_nettype none

// Partition allocator: keeps a base-ordered table of up to MAX_PARTITIONS
// partitions and serves init, append, allocate (first/best/worst fit) and
// free requests, one at a time. Allocate and free walk the table through
// its single read port, one entry per cycle. An allocation that splits an
// entry first shifts the entries above the pick up by one, and a dynamic
// free ends with a compaction pass over the table. A finished response is
// held in an output register, so the next request is accepted while it
// waits. No clearing pass is needed after reset; config is written via the
// csr port while idle: that is a rule for the user, the block does not enforce it.
module partition_allocator import pa_pkg::*; #(
   parameter int MAX_PARTITIONS = PA_MAX_PARTITIONS,
   parameter int ADDR_BITS      = PA_ADDR_BITS
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_wr_en,
   input  wire logic [1:0]           csr_index,
   input  wire logic [ADDR_BITS:0]   csr_data,
   pa_req_if.sink                    req_chan,
   pa_rsp_if.source                  rsp_chan
);

   pa_cmd_type  cmd;
   pa_stat_type stat;

   pa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   pa_datapath #(
      .MAX_PARTITIONS (MAX_PARTITIONS),
      .ADDR_BITS      (ADDR_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_func   (req_chan.func),
      .req_size   (req_chan.req_size),
      .req_base   (req_chan.req_base),
      .rsp_ready  (rsp_chan.ready),
      .rsp_valid  (rsp_chan.valid),
      .rsp_status (rsp_chan.status),
      .rsp_base   (rsp_chan.granted_base),
      .rsp_size   (rsp_chan.granted_size),
      .rsp_count  (rsp_chan.entry_count)
   );

endmodule

`default_nettype wire
